/* sv/rsp_pkg.sv */
// ----------------------------------------------------------------------------
// rsp_pkg: shared types, constants and helpers of the road segment projector
// Register indexes, stream payload layouts, reset values and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsp_pkg;

    // Default geometry, used as the defaults of the top level parameters
    localparam int SCREEN_WIDTH_DEF    = 1024;
    localparam int SCREEN_HEIGHT_DEF   = 768;
    localparam int ROAD_WIDTH_DEF      = 2000;
    localparam int SCALE_FRAC_BITS_DEF = 16;

    // Width of the shared adder at the default geometry
    localparam int ALU_WIDTH_DEF = 66;

    // Port widths
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 112;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    // Configuration register reset values
    localparam logic signed [15:0] CAMERA_X_RESET     = 16'sd0;
    localparam logic signed [15:0] CAMERA_Y_RESET     = 16'sd1500;
    localparam logic        [21:0] CAMERA_Z_RESET     = 22'd0;
    localparam logic        [15:0] CAMERA_DEPTH_RESET = 16'd213;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_X     = 2'd0,
        REG_CAMERA_Y     = 2'd1,
        REG_CAMERA_Z     = 2'd2,
        REG_CAMERA_DEPTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] camera_x;
        logic signed [15:0] camera_y;
        logic        [21:0] camera_z;
        logic        [15:0] camera_depth;
    } cam_cfg_t;

    typedef struct packed {
        logic               frame_start;
        logic        [11:0] seg_number;
        logic        [21:0] seg_depth;
        logic signed [15:0] seg_height;
        logic signed [8:0]  seg_curve;
    } seg_item_t;

    typedef struct packed {
        logic signed [15:0] top_row;
        logic signed [15:0] top_center;
        logic        [15:0] top_half_width;
        logic signed [15:0] bottom_row;
        logic signed [15:0] bottom_center;
        logic        [15:0] bottom_half_width;
        logic               stripe;
        logic        [9:0]  clip_row;
    } proj_result_t;

    // Saturate to the signed 16 bit range
    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Saturate to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh07FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -33'sh080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp a row to 0..1023
    function automatic logic [9:0] clip10(input logic signed [15:0] v);
        logic [9:0] r;
        if (v < 16'sd0) begin
            r = 10'd0;
        end else if (v > 16'sd1023) begin
            r = 10'd1023;
        end else begin
            r = v[9:0];
        end
        return r;
    endfunction

    // (n div 3) mod 2; n * 2731 / 8192 equals n div 3 for every 12 bit n
    function automatic logic stripe_bit(input logic [11:0] n);
        logic [25:0] p;
        p = 26'(n) * 26'd2731;
        return p[13];
    endfunction

endpackage

/* sv/rsp_alu.sv */
// ----------------------------------------------------------------------------
// rsp_alu: shared adder / subtractor
// One wide add or subtract with carry out; serves the divider's trial
// subtract and the multiplier's shift-add step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsp_alu #(
    parameter int WIDTH = rsp_pkg::ALU_WIDTH_DEF
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH:0]   sum
);

    logic [WIDTH:0] b_ext;

    // Top bit of a subtract is set when a < b
    assign b_ext = {1'b0, b} ^ {(WIDTH + 1){sub}};
    assign sum   = {1'b0, a} + b_ext + (WIDTH + 1)'(sub);

endmodule

/* sv/rsp_engine.sv */
// ----------------------------------------------------------------------------
// rsp_engine: segment projection sequencer
// Runs the scale division and the three projection products through one
// shared adder, then updates the horizon, previous edge and curve sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsp_engine #(
    parameter int SCREEN_WIDTH    = rsp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT   = rsp_pkg::SCREEN_HEIGHT_DEF,
    parameter int ROAD_WIDTH      = rsp_pkg::ROAD_WIDTH_DEF,
    parameter int SCALE_FRAC_BITS = rsp_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rsp_pkg::cam_cfg_t    cfg,
    input  logic                 start,
    input  rsp_pkg::seg_item_t   item,
    output logic                 idle,
    output logic                 res_valid,
    input  logic                 res_ready,
    output rsp_pkg::proj_result_t res
);

    localparam int HALF_W = SCREEN_WIDTH / 2;
    localparam int HALF_H = SCREEN_HEIGHT / 2;
    localparam int NW     = SCALE_FRAC_BITS + 8;          // numerator and scale bits
    localparam int YW     = NW;                           // serial operand bits
    localparam int HWB    = $clog2(HALF_W + 1);
    localparam int VWB    = $clog2(HALF_H + 1);
    localparam int CB     = (HWB > VWB) ? HWB : VWB;
    localparam int MW     = 32 + CB;                      // multiplicand bits
    localparam int PW     = MW + NW;                      // product bits
    localparam int CW     = $clog2(NW);
    localparam longint ROAD_K = longint'(ROAD_WIDTH) * longint'(HALF_W);

    localparam logic [YW-1:0] CA_Y = YW'(HALF_W) << (YW - HWB);
    localparam logic [YW-1:0] RA_Y = YW'(HALF_H) << (YW - VWB);
    localparam logic [PW-1:0] MASK_BIG   = (PW'(1) << (SCALE_FRAC_BITS + 8)) - PW'(1);
    localparam logic [PW-1:0] MASK_SMALL = (PW'(1) << SCALE_FRAC_BITS) - PW'(1);
    localparam logic signed [19:0] HALF_W_S = 20'(HALF_W);
    localparam logic signed [19:0] HALF_H_S = 20'(HALF_H);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_DIV  = 11'b00000000010,
        ST_CA   = 11'b00000000100,
        ST_CB   = 11'b00000001000,
        ST_CF   = 11'b00000010000,
        ST_RA   = 11'b00000100000,
        ST_RB   = 11'b00001000000,
        ST_RF   = 11'b00010000000,
        ST_HB   = 11'b00100000000,
        ST_HF   = 11'b01000000000,
        ST_UPD  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;

    // Projection state
    logic signed [31:0] lat_off_reg, lat_step_reg;
    logic signed [15:0] horizon_reg;
    logic signed [15:0] prev_row_reg, prev_center_reg;
    logic        [15:0] prev_half_reg;
    logic               prev_front_reg;

    // Per segment working registers
    logic [PW-1:0]      acc_reg;
    logic [MW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic [YW-1:0]      scale_reg;
    logic [21:0]        dist_reg;
    logic               front_reg;
    logic [11:0]        number_reg;
    logic signed [15:0] height_reg;
    logic signed [8:0]  curve_reg;
    logic               neg_c_reg, neg_r_reg;
    logic signed [15:0] center_reg, row_reg;
    logic        [15:0] half_reg;

    // Shared unit step
    logic          div_mode;
    logic [PW-1:0] alu_a, alu_b;
    logic [PW:0]   alu_sum;
    logic          qbit;
    logic [PW-1:0] step_acc;
    logic [YW-1:0] step_y;
    logic [CW-1:0] last_cnt;
    logic          step_end;

    // Operands
    logic signed [22:0] dist_full;
    logic               dist_pos;
    logic signed [33:0] a_full;
    logic        [33:0] a_abs;
    logic signed [16:0] b_full;
    logic        [16:0] b_abs;

    // Round, saturate
    logic          fin_big, fin_neg;
    logic [PW-1:0] fin_shr;
    logic          fin_low_nz;
    logic [PW-1:0] fin_mag;
    logic [17:0]   fin_sat;
    logic signed [18:0] fin_val;
    logic signed [19:0] fin_ext;

    // Update
    logic visible, produce, commit;

    assign div_mode = (state_reg == ST_DIV);
    assign alu_a    = {acc_reg[PW-2:0], div_mode & y_reg[YW-1]};
    assign alu_b    = div_mode ? PW'(dist_reg) : (y_reg[YW-1] ? PW'(x_reg) : '0);

    rsp_alu #(
        .WIDTH (PW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (div_mode),
        .sum (alu_sum)
    );

    // Keep the trial difference only when it did not go negative
    assign qbit     = ~alu_sum[PW];
    assign step_acc = (div_mode && !qbit) ? alu_a : alu_sum[PW-1:0];
    assign step_y   = {y_reg[YW-2:0], div_mode & qbit};

    always_comb begin
        case (state_reg)
            ST_CA:   last_cnt = CW'(HWB - 1);
            ST_RA:   last_cnt = CW'(VWB - 1);
            default: last_cnt = CW'(NW - 1);
        endcase
    end
    assign step_end = (cnt_reg == last_cnt);

    assign dist_full = $signed({1'b0, item.seg_depth}) - $signed({1'b0, cfg.camera_z});
    assign dist_pos  = !dist_full[22] && (dist_full[21:0] != 22'd0);

    assign a_full = 34'(lat_off_reg) - 34'($signed({cfg.camera_x, 8'd0}));
    assign a_abs  = a_full[33] ? 34'(-a_full) : a_full;
    assign b_full = 17'(height_reg) - 17'(cfg.camera_y);
    assign b_abs  = b_full[16] ? 17'(-b_full) : b_full;

    // Floor of the signed product over 2^k, saturated well past the 16 bit range
    assign fin_big    = (state_reg == ST_CF);
    assign fin_neg    = (state_reg == ST_CF) ? neg_c_reg :
                        ((state_reg == ST_RF) ? neg_r_reg : 1'b0);
    assign fin_shr    = fin_big ? (acc_reg >> (SCALE_FRAC_BITS + 8)) : (acc_reg >> SCALE_FRAC_BITS);
    assign fin_low_nz = fin_big ? |(acc_reg & MASK_BIG) : |(acc_reg & MASK_SMALL);
    assign fin_mag    = fin_shr + PW'(fin_neg & fin_low_nz);
    assign fin_sat    = (|fin_mag[PW-1:17]) ? 18'h20000 : fin_mag[17:0];
    assign fin_val    = fin_neg ? -$signed({1'b0, fin_sat}) : $signed({1'b0, fin_sat});
    assign fin_ext    = 20'(fin_val);

    assign visible = front_reg && ($signed(row_reg) < $signed(horizon_reg));
    assign produce = visible && prev_front_reg;
    assign commit  = (state_reg == ST_UPD) && (!produce || res_ready);

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_UPD) && produce && res_ready;

    always_comb begin
        res.top_row           = prev_row_reg;
        res.top_center        = prev_center_reg;
        res.top_half_width    = prev_half_reg;
        res.bottom_row        = row_reg;
        res.bottom_center     = center_reg;
        res.bottom_half_width = half_reg;
        res.stripe            = rsp_pkg::stripe_bit(number_reg);
        res.clip_row          = rsp_pkg::clip10(horizon_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = dist_pos ? ST_DIV : ST_UPD;
                end
            end
            ST_DIV:  if (step_end) state_next = ST_CA;
            ST_CA:   if (step_end) state_next = ST_CB;
            ST_CB:   if (step_end) state_next = ST_CF;
            ST_CF:   state_next = ST_RA;
            ST_RA:   if (step_end) state_next = ST_RB;
            ST_RB:   if (step_end) state_next = ST_RF;
            ST_RF:   state_next = ST_HB;
            ST_HB:   if (step_end) state_next = ST_HF;
            ST_HF:   state_next = ST_UPD;
            ST_UPD:  if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and projection state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            lat_off_reg     <= '0;
            lat_step_reg    <= '0;
            horizon_reg     <= 16'(SCREEN_HEIGHT);
            prev_row_reg    <= '0;
            prev_center_reg <= '0;
            prev_half_reg   <= '0;
            prev_front_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DIV || state_reg == ST_CA || state_reg == ST_CB ||
                state_reg == ST_RA || state_reg == ST_RB || state_reg == ST_HB) begin
                cnt_reg <= step_end ? '0 : cnt_reg + CW'(1);
            end else begin
                cnt_reg <= '0;
            end
            if (idle && start && item.frame_start) begin
                lat_off_reg    <= '0;
                lat_step_reg   <= '0;
                horizon_reg    <= 16'(SCREEN_HEIGHT);
                prev_front_reg <= 1'b0;
            end
            if (commit) begin
                if (front_reg) begin
                    if (visible) begin
                        horizon_reg <= row_reg;
                    end
                    prev_row_reg    <= row_reg;
                    prev_center_reg <= center_reg;
                    prev_half_reg   <= half_reg;
                    prev_front_reg  <= 1'b1;
                end else begin
                    prev_front_reg  <= 1'b0;
                end
                lat_off_reg  <= rsp_pkg::sat32(33'(lat_off_reg) + 33'(lat_step_reg));
                lat_step_reg <= rsp_pkg::sat32(33'(lat_step_reg) + 33'(curve_reg));
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    number_reg <= item.seg_number;
                    height_reg <= item.seg_height;
                    curve_reg  <= item.seg_curve;
                    front_reg  <= dist_pos;
                    dist_reg   <= dist_full[21:0];
                    acc_reg    <= '0;
                    y_reg      <= YW'(cfg.camera_depth) << (SCALE_FRAC_BITS - 8);
                end
            end
            ST_DIV: begin
                if (step_end) begin
                    scale_reg <= step_y;
                    x_reg     <= MW'(a_abs[31:0]);
                    y_reg     <= CA_Y;
                    acc_reg   <= '0;
                    neg_c_reg <= a_full[33];
                end else begin
                    acc_reg <= step_acc;
                    y_reg   <= step_y;
                end
            end
            ST_CA, ST_RA: begin
                if (step_end) begin
                    x_reg   <= step_acc[MW-1:0];
                    y_reg   <= scale_reg;
                    acc_reg <= '0;
                end else begin
                    acc_reg <= step_acc;
                    y_reg   <= step_y;
                end
            end
            ST_CB, ST_RB, ST_HB: begin
                acc_reg <= step_acc;
                y_reg   <= step_y;
            end
            ST_CF: begin
                center_reg <= rsp_pkg::sat16(HALF_W_S + fin_ext);
                x_reg      <= MW'(b_abs);
                y_reg      <= RA_Y;
                acc_reg    <= '0;
                neg_r_reg  <= b_full[16];
            end
            ST_RF: begin
                row_reg <= rsp_pkg::sat16(HALF_H_S - fin_ext);
                x_reg   <= MW'(ROAD_K);
                y_reg   <= scale_reg;
                acc_reg <= '0;
            end
            ST_HF: begin
                half_reg <= (fin_sat[17:16] != 2'b00) ? 16'hFFFF : fin_sat[15:0];
            end
            ST_UPD: begin
                // hold until the result is taken
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_res_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> res_ready)
        else $error("result issued while the output register is full");

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (state_reg == ST_DIV || state_reg == ST_UPD))
        else $error("accepted request did not start the sequence");

    a_res_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after a result");

    a_horizon_rises: assert property (@(posedge aclk) disable iff (!aresetn)
        !(start && item.frame_start) |=> ($signed(horizon_reg) <= $signed($past(horizon_reg))))
        else $error("horizon moved down within a frame");
`endif

endmodule

/* sv/road_segment_projector_core.sv */
// ----------------------------------------------------------------------------
// road_segment_projector_core: pseudo 3D road segment projector
// Projected segment: run through the bit serial divider and multiplier sharing one adder; a new request is taken only once the engine is idle again.
// Result held in the output register; a segment behind the camera skips the divider and multiplier and goes straight to the update.
// Synchronous active low reset; camera registers, curve sums, horizon and previous edge return to their reset values at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module road_segment_projector_core #(
    parameter int SCREEN_WIDTH    = rsp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT   = rsp_pkg::SCREEN_HEIGHT_DEF,
    parameter int ROAD_WIDTH      = rsp_pkg::ROAD_WIDTH_DEF,
    parameter int SCALE_FRAC_BITS = rsp_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // seg_number[11:0], seg_depth[33:12], seg_height[49:34], seg_curve[58:50], zero
    input  logic [rsp_pkg::S_TDATA_W-1:0]  s_tdata,
    // frame_start[0]
    input  logic [0:0]                     s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // top_row[15:0], top_center[31:16], top_half_width[47:32], bottom_row[63:48],
    // bottom_center[79:64], bottom_half_width[95:80], clip_row[105:96], zero
    output logic [rsp_pkg::M_TDATA_W-1:0]  m_tdata,
    // stripe[0]
    output logic [0:0]                     m_tuser
);

    rsp_pkg::cam_cfg_t     cfg_reg;
    rsp_pkg::seg_item_t    item;
    rsp_pkg::proj_result_t res;
    rsp_pkg::proj_result_t out_reg;
    logic                  out_valid_reg;
    logic                  eng_idle, start, res_valid, res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.camera_x     <= rsp_pkg::CAMERA_X_RESET;
            cfg_reg.camera_y     <= rsp_pkg::CAMERA_Y_RESET;
            cfg_reg.camera_z     <= rsp_pkg::CAMERA_Z_RESET;
            cfg_reg.camera_depth <= rsp_pkg::CAMERA_DEPTH_RESET;
        end else if (cfg_valid) begin
            unique case (rsp_pkg::cfg_reg_t'(cfg_index))
                rsp_pkg::REG_CAMERA_X:     cfg_reg.camera_x     <= cfg_data[15:0];
                rsp_pkg::REG_CAMERA_Y:     cfg_reg.camera_y     <= cfg_data[15:0];
                rsp_pkg::REG_CAMERA_Z:     cfg_reg.camera_z     <= cfg_data[21:0];
                rsp_pkg::REG_CAMERA_DEPTH: cfg_reg.camera_depth <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign item.frame_start = s_tuser[0];
    assign item.seg_number  = s_tdata[11:0];
    assign item.seg_depth   = s_tdata[33:12];
    assign item.seg_height  = s_tdata[49:34];
    assign item.seg_curve   = s_tdata[58:50];

    assign s_tready  = eng_idle;
    assign start     = s_tvalid && eng_idle;
    assign res_ready = !out_valid_reg || m_tready;

    rsp_engine #(
        .SCREEN_WIDTH    (SCREEN_WIDTH),
        .SCREEN_HEIGHT   (SCREEN_HEIGHT),
        .ROAD_WIDTH      (ROAD_WIDTH),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .start     (start),
        .item      (item),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.clip_row,
                       out_reg.bottom_half_width, out_reg.bottom_center, out_reg.bottom_row,
                       out_reg.top_half_width, out_reg.top_center, out_reg.top_row};
    assign m_tuser  = out_reg.stripe;

endmodule

/* verif/road_segment_projector_checker.sv */
// ----------------------------------------------------------------------------
// road_segment_projector_checker: projection predictor and result scoreboard
// Watches the register, segment and trapezoid channels of the projector. Each
// accepted segment is run through a behavioural copy of the projection, the
// trapezoids it should emit are queued, and every emitted trapezoid is checked
// field by field against the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module road_segment_projector_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [rsp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rsp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [0:0]                     m_tuser,
    output int                             mismatch_count,
    output int                             pending_count
);

    localparam int     HALF_W      = rsp_pkg::SCREEN_WIDTH_DEF / 2;
    localparam int     HALF_H      = rsp_pkg::SCREEN_HEIGHT_DEF / 2;
    localparam int     FRAC        = rsp_pkg::SCALE_FRAC_BITS_DEF;
    localparam longint PRODUCT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MAX     = 64'sd2147483647;
    localparam longint SUM_MIN     = -64'sd2147483648;

    // camera registers
    longint cam_x;
    longint cam_y;
    longint cam_z;
    longint cam_depth;

    // per frame state
    longint curve_offset;
    longint curve_step;
    longint horizon;
    longint edge_row;
    longint edge_center;
    longint edge_half;
    bit     edge_valid;

    rsp_pkg::proj_result_t expected_trapezoids[$];

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat_product(input longint a, input longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] p;
        wa = a;
        wb = b;
        p  = wa * wb;
        if (p > PRODUCT_MAX) begin
            return PRODUCT_MAX;
        end else if (p < -PRODUCT_MAX) begin
            return -PRODUCT_MAX;
        end
        return longint'(p[63:0]);
    endfunction

    task automatic project_segment(input rsp_pkg::seg_item_t seg);
        longint                gap;
        longint                scale;
        longint                t;
        longint                row;
        longint                center;
        longint                half;
        longint                horizon_was;
        rsp_pkg::proj_result_t trap;
        if (seg.frame_start) begin
            curve_offset = 0;
            curve_step   = 0;
            horizon      = rsp_pkg::SCREEN_HEIGHT_DEF;
            edge_valid   = 1'b0;
        end
        gap = longint'(seg.seg_depth) - cam_z;
        if (gap <= 0) begin
            // behind the camera: keep the edge, forget that it was drawable
            edge_valid = 1'b0;
        end else begin
            scale  = (cam_depth << (FRAC - 8)) / gap;
            t      = sat_product(sat_product(scale, curve_offset - cam_x * 256), HALF_W);
            center = clamp_to(HALF_W + (t >>> (FRAC + 8)), -32768, 32767);
            t      = sat_product(sat_product(scale,
                         longint'($signed(seg.seg_height)) - cam_y), HALF_H);
            row    = clamp_to(HALF_H - (t >>> FRAC), -32768, 32767);
            t      = sat_product(scale, longint'(rsp_pkg::ROAD_WIDTH_DEF) * HALF_W);
            half   = clamp_to(t >>> FRAC, 0, 65535);

            horizon_was = horizon;
            if (row < horizon) begin
                horizon = row;
                if (edge_valid) begin
                    trap.top_row           = edge_row[15:0];
                    trap.top_center        = edge_center[15:0];
                    trap.top_half_width    = edge_half[15:0];
                    trap.bottom_row        = row[15:0];
                    trap.bottom_center     = center[15:0];
                    trap.bottom_half_width = half[15:0];
                    trap.stripe            = 1'((seg.seg_number / 3) % 2);
                    trap.clip_row          = 10'(clamp_to(horizon_was, 0, 1023));
                    expected_trapezoids    = {expected_trapezoids, trap};
                end
            end
            edge_row    = row;
            edge_center = center;
            edge_half   = half;
            edge_valid  = 1'b1;
        end
        curve_offset = clamp_to(curve_offset + curve_step, SUM_MIN, SUM_MAX);
        curve_step   = clamp_to(curve_step + longint'($signed(seg.seg_curve)), SUM_MIN, SUM_MAX);
    endtask

    task automatic check_field(input string label, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        rsp_pkg::seg_item_t    seg;
        rsp_pkg::proj_result_t want;
        if (!aresetn) begin
            cam_x          = longint'(rsp_pkg::CAMERA_X_RESET);
            cam_y          = longint'(rsp_pkg::CAMERA_Y_RESET);
            cam_z          = longint'(rsp_pkg::CAMERA_Z_RESET);
            cam_depth      = longint'(rsp_pkg::CAMERA_DEPTH_RESET);
            curve_offset   = 0;
            curve_step     = 0;
            horizon        = rsp_pkg::SCREEN_HEIGHT_DEF;
            edge_row       = 0;
            edge_center    = 0;
            edge_half      = 0;
            edge_valid     = 1'b0;
            mismatch_count = 0;
            expected_trapezoids.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (rsp_pkg::cfg_reg_t'(cfg_index))
                    rsp_pkg::REG_CAMERA_X:     cam_x     = longint'($signed(cfg_data[15:0]));
                    rsp_pkg::REG_CAMERA_Y:     cam_y     = longint'($signed(cfg_data[15:0]));
                    rsp_pkg::REG_CAMERA_Z:     cam_z     = longint'(cfg_data[21:0]);
                    rsp_pkg::REG_CAMERA_DEPTH: cam_depth = longint'(cfg_data[15:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_trapezoids.size() == 0) begin
                    $display("%0t: unexpected trapezoid, expected none, got %h stripe %b",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_trapezoids.pop_front();
                    check_field("top_row", $signed(want.top_row), $signed(m_tdata[15:0]));
                    check_field("top_center", $signed(want.top_center),
                                $signed(m_tdata[31:16]));
                    check_field("top_half_width", want.top_half_width, m_tdata[47:32]);
                    check_field("bottom_row", $signed(want.bottom_row),
                                $signed(m_tdata[63:48]));
                    check_field("bottom_center", $signed(want.bottom_center),
                                $signed(m_tdata[79:64]));
                    check_field("bottom_half_width", want.bottom_half_width, m_tdata[95:80]);
                    check_field("clip_row", want.clip_row, m_tdata[105:96]);
                    check_field("stripe", want.stripe, m_tuser[0]);
                end
            end
            if (s_tvalid && s_tready) begin
                seg.frame_start = s_tuser[0];
                seg.seg_number  = s_tdata[11:0];
                seg.seg_depth   = s_tdata[33:12];
                seg.seg_height  = s_tdata[49:34];
                seg.seg_curve   = s_tdata[58:50];
                project_segment(seg);
            end
        end
        pending_count = expected_trapezoids.size();
    end

endmodule

/* verif/tb_road_segment_projector_core.sv */
// ----------------------------------------------------------------------------
// tb_road_segment_projector_core: testbench of the road segment projector
// Drives directed and randomised road frames under several camera settings,
// with random idling on both streams and one long output hold-off. The
// checker beside the core predicts every trapezoid; this module gives the
// verdict once the core has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_road_segment_projector_core;

    localparam int LATENCY = 4 * (rsp_pkg::SCALE_FRAC_BITS_DEF + 8)
                             + $clog2(rsp_pkg::SCREEN_WIDTH_DEF / 2 + 1)
                             + $clog2(rsp_pkg::SCREEN_HEIGHT_DEF / 2 + 1) + 5;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RX_HOLD_CYCLES  = 2000;
    localparam int SWEEP_SEGMENTS  = 120;
    localparam int DEPTH_MAX       = 4194303;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rsp_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [0:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rsp_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [0:0]                     m_tuser;

    int   mismatch_count;
    int   pending_count;
    logic seg_taken = 1'b0;
    logic reg_taken = 1'b0;
    int   tx_idle_pct = 30;
    int   rx_idle_pct = 30;
    bit   stall_request = 1'b0;
    bit   stall_done = 1'b0;
    int   quiet_cycles = 0;
    int   sh_cam_y = 1500;
    int   sh_cam_z = 0;
    int   seg_count = 0;

    road_segment_projector_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    road_segment_projector_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // handshakes seen at the last rising edge, read by the drivers at the falling edge
    always @(posedge aclk) begin
        seg_taken <= s_tvalid && s_tready;
        reg_taken <= cfg_valid && cfg_ready;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** road_segment_projector_core: FAILED **");
            $finish;
        end
    end

    // trapezoid receiver: random back-pressure, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request && !stall_done) begin
                stall_done = 1'b1;
                m_tready   = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_seg(input rsp_pkg::seg_item_t seg);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        if (tx_idle_pct > 0 && $urandom_range(99) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(200, 20)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'd0, seg.seg_curve, seg.seg_height, seg.seg_depth, seg.seg_number};
        s_tuser  = seg.frame_start;
        do @(negedge aclk); while (!seg_taken);
        seg_count++;
    endtask

    task automatic send_fields(input bit fs, input int num, input int depth,
                               input int height, input int curve);
        rsp_pkg::seg_item_t seg;
        seg.frame_start = fs;
        seg.seg_number  = 12'(num);
        seg.seg_depth   = 22'(depth);
        seg.seg_height  = 16'(height);
        seg.seg_curve   = 9'(curve);
        send_seg(seg);
    endtask

    // hold the request until accepted; valid is left high for the caller to drop
    task automatic write_reg(input rsp_pkg::cfg_reg_t idx,
                             input logic [rsp_pkg::CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(negedge aclk); while (!reg_taken);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    task automatic set_camera(input int x, input int y, input int z, input int depth);
        settle();
        write_reg(rsp_pkg::REG_CAMERA_X, {6'($urandom), 16'(x)});
        write_reg(rsp_pkg::REG_CAMERA_Y, {6'($urandom), 16'(y)});
        write_reg(rsp_pkg::REG_CAMERA_Z, 22'(z));
        write_reg(rsp_pkg::REG_CAMERA_DEPTH, {6'($urandom), 16'(depth)});
        cfg_valid = 1'b0;
        sh_cam_y  = y;
        sh_cam_z  = z;
    endtask

    task automatic set_random_camera();
        int z;
        z = ($urandom_range(2) == 0) ? $urandom_range(1000) : $urandom_range(3000000);
        set_camera($urandom_range(65535) - 32768, $urandom_range(65535) - 32768, z,
                   $urandom_range(65535));
    endtask

    // build up large curve sums behind the camera, then project a few edges
    task automatic curve_sweep(input int curve);
        int k;
        tx_idle_pct = 0;
        for (k = 0; k < SWEEP_SEGMENTS; k++) begin
            send_fields(k == 0, k, 0, $urandom_range(65535), curve);
        end
        for (k = 1; k <= 6; k++) begin
            send_fields(1'b0, k, sh_cam_z + k, sh_cam_y - $urandom_range(4000), curve);
        end
        tx_idle_pct = 30;
    endtask

    // mostly well-formed frames receding from the camera, with noise mixed in
    task automatic run_frames(input int count);
        rsp_pkg::seg_item_t seg;
        int                 left;
        int                 flen;
        int                 k;
        int                 dcur;
        int                 hcur;
        int                 num;
        left = count;
        num  = $urandom_range(4095);
        while (left > 0) begin
            flen = $urandom_range(40, 4);
            if (flen > left) begin
                flen = left;
            end
            dcur = sh_cam_z + $urandom_range(300, 1);
            hcur = ($urandom_range(3) == 0) ? $urandom_range(65535) - 32768
                                            : sh_cam_y - $urandom_range(3000);
            for (k = 0; k < flen; k++) begin
                if (dcur > DEPTH_MAX) begin
                    dcur = DEPTH_MAX;
                end
                hcur = hcur + $urandom_range(200) - 100;
                hcur = (hcur > 32767) ? 32767 : ((hcur < -32768) ? -32768 : hcur);
                if ($urandom_range(99) < 12) begin
                    seg.frame_start = 1'($urandom_range(1));
                    seg.seg_number  = 12'($urandom);
                    seg.seg_depth   = 22'($urandom_range(DEPTH_MAX));
                    seg.seg_height  = 16'($urandom);
                    seg.seg_curve   = 9'($urandom);
                end else begin
                    seg.frame_start = (k == 0);
                    seg.seg_number  = 12'(num);
                    seg.seg_depth   = ($urandom_range(19) == 0) ? 22'($urandom_range(sh_cam_z))
                                                               : 22'(dcur);
                    seg.seg_height  = 16'(hcur);
                    seg.seg_curve   = 9'($urandom);
                    num++;
                end
                send_seg(seg);
                // occasionally repeat a depth so two segments lie at the same distance
                if ($urandom_range(19) != 0) begin
                    dcur = dcur + $urandom_range(1 << $urandom_range(16, 2), 1);
                end
                left--;
            end
        end
    endtask

    initial begin
        int k;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // reset camera: first of frame, visible, culled, behind, successor, clipped rows
        send_fields(1'b1, 0, 10, 0, 0);
        send_fields(1'b0, 1, 20, 0, 255);
        send_fields(1'b0, 2, 40, -32768, -256);
        send_fields(1'b0, 3, 0, 0, 0);
        send_fields(1'b0, 4, 100, 1652, 0);
        send_fields(1'b0, 5, 110, 32767, 0);
        send_fields(1'b0, 6, DEPTH_MAX, 32767, 255);
        send_fields(1'b1, 4095, 1, -32768, 255);
        send_fields(1'b0, 7, 200, 0, 0);
        send_fields(1'b0, 8, DEPTH_MAX, 0, -256);
        send_fields(1'b0, 9, DEPTH_MAX, 0, 0);
        send_fields(1'b1, 10, 0, 0, 0);
        send_fields(1'b0, 11, 5, 0, 0);
        for (k = 0; k < 8; k++) begin
            send_fields(1'b0, 12 + k, 20 << k, 0, (k % 2 == 0) ? 255 : -256);
        end

        set_camera(0, 1500, 0, 213);
        run_frames(100);

        set_camera(-32768, 32767, 0, 65535);
        curve_sweep(255);
        curve_sweep(-256);
        run_frames(80);

        set_camera(32767, -32768, DEPTH_MAX, 0);
        run_frames(40);

        // stretch without any idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_random_camera();
        run_frames(150);
        tx_idle_pct = 30;
        rx_idle_pct = 30;

        set_random_camera();
        stall_request = 1'b1;
        run_frames(150);

        repeat (3) begin
            set_random_camera();
            run_frames(120);
        end

        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (2 * LATENCY) @(negedge aclk);
        if (pending_count != 0) begin
            $display("%0t: %0d expected trapezoids never arrived", $time, pending_count);
        end
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("** road_segment_projector_core: PASSED **");
        end else begin
            $display("** road_segment_projector_core: FAILED **");
        end
        $finish;
    end

endmodule
